>>> rtl/hcd_pkg.sv
// shared types, constants and helpers of the harris corner detector
`default_nettype none
package hcd_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int COL_W          = 10;
    localparam int ROW_W          = 12;
    localparam int RING_ROWS_LOG2 = 3;
    localparam int PIX_ADDR_W     = RING_ROWS_LOG2 + COL_W;
    localparam int RESP_W         = 52;
    localparam int SUM_W          = 24;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [23:0] RST_THRESHOLD    = 24'd500000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CELL,
        S_RD,
        S_ACC,
        S_START,
        S_WAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic        [SUM_W-1:0] a;
        logic signed [SUM_W:0]   b;
        logic        [SUM_W-1:0] c;
    } t_sums;

    // row offset of a 3x3 position, raster order
    function automatic logic signed [1:0] cell_dy(input logic [3:0] idx);
        logic signed [1:0] v;
        case (idx)
            4'd0, 4'd1, 4'd2: v = -2'sd1;
            4'd3, 4'd4, 4'd5: v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction

    // column offset of a 3x3 position, raster order
    function automatic logic signed [1:0] cell_dx(input logic [3:0] idx);
        logic signed [1:0] v;
        case (idx)
            4'd0, 4'd3, 4'd6: v = -2'sd1;
            4'd1, 4'd4, 4'd7: v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/hcd_if.sv
// stream and configuration channel interfaces
`default_nettype none
interface hcd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] pixel;
    modport source (output valid, output mode, output pixel, input ready);
    modport sink (input valid, input mode, input pixel, output ready);
endinterface

interface hcd_out_if;
    logic               valid;
    logic               ready;
    logic [11:0]        row;
    logic [9:0]         column;
    logic               corner;
    logic signed [51:0] response_x25;
    logic               last;
    modport source (output valid, output row, output column, output corner,
                    output response_x25, output last, input ready);
    modport sink (input valid, input row, input column, input corner,
                  input response_x25, input last, output ready);
endinterface

interface hcd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/hcd_pixel_ram.sv
// simple dual-port pixel line memory with a registered read port
`default_nettype none
module hcd_pixel_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/hcd_resp.sv
// determinant, trace, response and eigenvalue tests over one shared multiplier
`default_nettype none
module hcd_resp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire hcd_pkg::t_sums        i_sums,
    input  wire logic [23:0]           i_threshold,
    output logic                       o_done,
    output logic signed [51:0]         o_resp,
    output logic                       o_corner
);
    import hcd_pkg::*;

    logic               r_busy;
    logic [2:0]         r_step;
    logic [24:0]        r_tr;
    logic signed [51:0] r_p_ac, r_p_bb, r_p_tt, r_p_t2, r_p_ttr;
    logic signed [51:0] r_det;
    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] prod;
    logic signed [55:0] resp_full, eig_term, t25;

    always_comb begin
        case (r_step)
            3'd0:    begin mul_a = 26'(i_sums.a);       mul_b = 26'(i_sums.c); end
            3'd1:    begin mul_a = 26'(i_sums.b);       mul_b = 26'(i_sums.b); end
            3'd2:    begin mul_a = 26'(r_tr);           mul_b = 26'(r_tr); end
            3'd3:    begin mul_a = 26'(i_threshold);    mul_b = 26'(i_threshold); end
            default: begin mul_a = 26'(i_threshold);    mul_b = 26'(r_tr); end
        endcase
        prod = mul_a * mul_b;
        // 25*det as shifts and adds
        resp_full = (56'(r_det) <<< 4) + (56'(r_det) <<< 3) + 56'(r_det) - 56'(r_p_tt);
        eig_term  = 56'(r_p_t2) - 56'(r_p_ttr) + 56'(r_det);
        t25       = 56'({32'd0, i_threshold}) * 56'sd25;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
                r_tr   <= 25'(i_sums.a) + 25'(i_sums.c);
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd0: r_p_ac  <= prod;
                    3'd1: r_p_bb  <= prod;
                    3'd2: r_p_tt  <= prod;
                    3'd3: r_p_t2  <= prod;
                    3'd4: begin
                        r_p_ttr <= prod;
                        r_det   <= r_p_ac - r_p_bb;
                    end
                    3'd5: begin
                        o_resp   <= resp_full[51:0];
                        o_corner <= ({1'b0, r_tr} > {1'b0, i_threshold, 1'b0})
                                    && (eig_term > 56'sd0) && (resp_full >= t25);
                        o_done   <= 1'b1;
                        r_busy   <= 1'b0;
                    end
                    default: r_busy <= 1'b0;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/harris_corner_detector.sv
// harris corner detector top level: line memory, window sequencer and output register
// a pixel that reports nothing is taken without a stall; a pixel that reports a result holds
// the input while the window is read through the single read port of the pixel memory
// (nine reads per gradient, up to nine gradients per result), the response unit and output stalls
// results lag the input by 2*width+2 items; flush items drain the tail of a frame
// synchronous active-low reset restores the registers to 640, 480, 500000 and clears counters
`default_nettype none
module harris_corner_detector (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hcd_in_if.sink     i_in,
    hcd_cfg_if.sink    i_cfg,
    hcd_out_if.source  o_out
);
    import hcd_pkg::*;

    t_state r_state, n_state;

    logic [10:0]        r_w;
    logic [12:0]        r_h;
    logic [23:0]        r_thr;
    logic [ROW_W-1:0]   r_in_row, r_out_row;
    logic [COL_W-1:0]   r_in_col, r_out_col;
    logic [11:0]        r_pending;
    logic               r_in_done;
    logic [3:0]         r_cell, r_cnt;
    logic signed [11:0] r_gx, r_gy;
    t_sums              r_sums;

    logic               r_o_valid, r_o_corner, r_o_last;
    logic [ROW_W-1:0]   r_o_row;
    logic [COL_W-1:0]   r_o_col;
    logic signed [51:0] r_o_resp;

    logic [10:0]        eff_w;
    logic [12:0]        eff_h;
    logic [11:0]        lead, pend_inc;
    logic               accept, emit_now, pix_item, in_row_end, in_frame_end;
    logic signed [13:0] cy, ny;
    logic signed [11:0] cx, nx;
    logic               cell_ok, out_free, out_last;
    logic [12:0]        my;
    logic [10:0]        mx;
    logic [3:0]         nb;
    logic [11:0]        mag_x, mag_y;
    logic [7:0]         rd_data;
    logic               rd_en, wr_en, resp_start, resp_done, resp_corner;
    logic [PIX_ADDR_W-1:0] rd_addr, wr_addr;
    logic signed [51:0] resp_val;
    logic signed [23:0] sq_x, sq_y, xy;

    // effective geometry
    always_comb begin
        if (r_w < 11'd3)              eff_w = 11'd3;
        else if (r_w > 11'(MAX_WIDTH)) eff_w = 11'(MAX_WIDTH);
        else                          eff_w = r_w;
        if (r_h < 13'd3)              eff_h = 13'd3;
        else if (r_h > 13'(MAX_HEIGHT)) eff_h = 13'(MAX_HEIGHT);
        else                          eff_h = r_h;
        lead     = {eff_w, 1'b0} + 12'd2;
        pend_inc = r_pending + 12'd1;
    end

    assign accept       = i_in.valid && i_in.ready;
    assign pix_item     = !r_in_done && !i_in.mode;
    assign emit_now     = r_in_done || (pix_item && (pend_inc > lead));
    assign in_row_end   = (11'(r_in_col) + 11'd1) >= eff_w;
    assign in_frame_end = (13'(r_in_row) + 13'd1) >= eff_h;
    assign out_free     = !r_o_valid || o_out.ready;
    assign out_last     = (13'(r_out_row) == eff_h - 13'd1)
                          && (11'(r_out_col) == eff_w - 11'd1);

    // window position and mirrored neighbor address
    always_comb begin
        logic signed [1:0] dy, dx, ey, ex;
        dy = cell_dy(r_cell);
        dx = cell_dx(r_cell);
        ey = cell_dy(r_cnt);
        ex = cell_dx(r_cnt);
        cy = $signed({2'b00, r_out_row}) + {{12{dy[1]}}, dy};
        cx = $signed({2'b00, r_out_col}) + {{10{dx[1]}}, dx};
        cell_ok = !cy[13] && (cy[12:0] < eff_h) && !cx[11] && (cx[10:0] < eff_w);
        ny = cy + {{12{ey[1]}}, ey};
        nx = cx + {{10{ex[1]}}, ex};
        if (ny[13])                 my = 13'd1;
        else if (ny[12:0] >= eff_h) my = eff_h - 13'd2;
        else                        my = ny[12:0];
        if (nx[11])                 mx = 11'd1;
        else if (nx[10:0] >= eff_w) mx = eff_w - 11'd2;
        else                        mx = nx[10:0];
        rd_addr = {my[RING_ROWS_LOG2-1:0], mx[COL_W-1:0]};
    end

    // sobel weights of the neighbor whose data arrives this cycle
    always_comb begin
        logic signed [1:0] ey, ex;
        nb = r_cnt - 4'd1;
        ey = cell_dy(nb);
        ex = cell_dx(nb);
        mag_x = (ey == 2'sd0) ? {3'd0, rd_data, 1'b0} : {4'd0, rd_data};
        mag_y = (ex == 2'sd0) ? {3'd0, rd_data, 1'b0} : {4'd0, rd_data};
        if (ex == 2'sd1)       mag_x = mag_x;
        else if (ex == -2'sd1) mag_x = -mag_x;
        else                   mag_x = 12'd0;
        if (ey == 2'sd1)       mag_y = mag_y;
        else if (ey == -2'sd1) mag_y = -mag_y;
        else                   mag_y = 12'd0;
        sq_x = r_gx * r_gx;
        sq_y = r_gy * r_gy;
        xy   = r_gx * r_gy;
    end

    assign wr_addr = {r_in_row[RING_ROWS_LOG2-1:0], r_in_col};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept && emit_now) n_state = S_CELL;
            S_CELL: begin
                if (cell_ok)              n_state = S_RD;
                else if (r_cell == 4'd8)  n_state = S_START;
            end
            S_RD:    if (r_cnt == 4'd9) n_state = S_ACC;
            S_ACC:   n_state = (r_cell == 4'd8) ? S_START : S_CELL;
            S_START: n_state = S_WAIT;
            S_WAIT:  if (resp_done) n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        resp_start = 1'b0;
        case (r_state)
            S_IDLE:  wr_en = accept && pix_item;
            S_RD:    rd_en = (r_cnt < 4'd9);
            S_START: resp_start = 1'b1;
            default: ;
        endcase
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_w       <= RST_FRAME_WIDTH;
            r_h       <= RST_FRAME_HEIGHT;
            r_thr     <= RST_THRESHOLD;
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_pending <= '0;
            r_in_done <= 1'b0;
            r_o_valid <= 1'b0;
            r_cell    <= '0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;
            if (r_o_valid && o_out.ready && !(r_state == S_FIN && out_free)) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
                        if (i_cfg.index == REG_FRAME_WIDTH) r_w <= i_cfg.data[10:0];
                        else                                r_h <= i_cfg.data[12:0];
                        r_in_row  <= '0;
                        r_in_col  <= '0;
                        r_out_row <= '0;
                        r_out_col <= '0;
                        r_pending <= '0;
                        r_in_done <= 1'b0;
                    end
                    REG_THRESHOLD: r_thr <= i_cfg.data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_cell <= '0;
                    r_sums <= '0;
                    if (accept && pix_item) begin
                        r_pending <= pend_inc;
                        if (in_row_end) begin
                            r_in_col <= '0;
                            if (in_frame_end) begin
                                r_in_row  <= '0;
                                r_in_done <= 1'b1;
                            end else begin
                                r_in_row <= r_in_row + 12'd1;
                            end
                        end else begin
                            r_in_col <= r_in_col + 10'd1;
                        end
                    end
                end
                S_CELL: begin
                    r_cnt <= '0;
                    r_gx  <= '0;
                    r_gy  <= '0;
                    if (!cell_ok && r_cell != 4'd8) r_cell <= r_cell + 4'd1;
                end
                S_RD: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt != 4'd0) begin
                        r_gx <= r_gx + $signed(mag_x);
                        r_gy <= r_gy + $signed(mag_y);
                    end
                end
                S_ACC: begin
                    r_sums.a <= r_sums.a + 24'(unsigned'(sq_x));
                    r_sums.c <= r_sums.c + 24'(unsigned'(sq_y));
                    r_sums.b <= r_sums.b + {xy[23], xy};
                    if (r_cell != 4'd8) r_cell <= r_cell + 4'd1;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_row    <= r_out_row;
                        r_o_col    <= r_out_col;
                        r_o_corner <= resp_corner;
                        r_o_resp   <= resp_val;
                        r_o_last   <= out_last;
                        if (out_last) begin
                            r_in_row  <= '0;
                            r_in_col  <= '0;
                            r_out_row <= '0;
                            r_out_col <= '0;
                            r_pending <= '0;
                            r_in_done <= 1'b0;
                        end else begin
                            if ((11'(r_out_col) + 11'd1) >= eff_w) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + 12'd1;
                            end else begin
                                r_out_col <= r_out_col + 10'd1;
                            end
                            if (r_pending != 12'd0) r_pending <= r_pending - 12'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    hcd_pixel_ram #(
        .ADDR_W (PIX_ADDR_W),
        .DATA_W (8)
    ) u_pixel_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.pixel),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    hcd_resp u_resp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (resp_start),
        .i_sums      (r_sums),
        .i_threshold (r_thr),
        .o_done      (resp_done),
        .o_resp      (resp_val),
        .o_corner    (resp_corner)
    );

    assign o_out.valid        = r_o_valid;
    assign o_out.row          = r_o_row;
    assign o_out.column       = r_o_col;
    assign o_out.corner       = r_o_corner;
    assign o_out.response_x25 = r_o_resp;
    assign o_out.last         = r_o_last;

    a_pending_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= lead + 12'd1)
        else $error("pending count beyond result lead");

    a_done_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_done |-> (r_in_row == '0) && (r_in_col == '0))
        else $error("input counters not cleared at frame end");

    a_read_to_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) && (r_cnt == 4'd9) |=> (r_state == S_ACC))
        else $error("gradient read sequence overran");

    a_start_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |=> (r_state == S_WAIT) && !resp_done)
        else $error("response unit finished too early");
endmodule
`default_nettype wire

>>> sim/tb_harris_corner_detector.sv
// self-checking testbench of the harris corner detector: directed table, random frames, scoreboard
`default_nettype none
module tb_harris_corner_detector;
    timeunit 1ns;
    timeprecision 1ps;
    import hcd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 150;
    localparam int RAND_ITEMS    = 520;
    localparam int WIDE_ITEMS    = 32;

    typedef enum logic [1:0] { OP_PIX, OP_FLUSH, OP_CFG } t_op;

    typedef struct packed {
        logic [11:0]        row;
        logic [9:0]         col;
        logic               corner;
        logic signed [51:0] resp;
        logic               last;
    } t_res;

    typedef struct {
        t_op                    op;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        bit                     chk;
        logic                   exp_corner;
        logic signed [51:0]     exp_resp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hcd_in_if  in_ch ();
    hcd_cfg_if cfg_ch ();
    hcd_out_if out_ch ();

    harris_corner_detector dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    byte unsigned line_ring [8][MAX_WIDTH];
    int unsigned  reg_w, reg_h, reg_thr;
    int           in_row, in_col, out_row, out_col, pending;
    bit           frame_in_done;

    t_res expected_q[$];
    int   n_err = 0;
    int   n_beats = 0;
    int   n_corners = 0;
    bit   quiet = 1'b0;

    function automatic int eff_width();
        return (reg_w < 3) ? 3 : (reg_w > MAX_WIDTH) ? MAX_WIDTH : int'(reg_w);
    endfunction

    function automatic int eff_height();
        return (reg_h < 3) ? 3 : (reg_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(reg_h);
    endfunction

    function automatic int mirror_idx(int v, int n);
        return (v < 0) ? 1 : (v >= n) ? n - 2 : v;
    endfunction

    function automatic longint ring_px(int y, int x, int w, int h);
        return longint'(line_ring[mirror_idx(y, h) & 7][mirror_idx(x, w)]);
    endfunction

    function automatic void clear_frame();
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        pending = 0; frame_in_done = 1'b0;
    endfunction

    function automatic t_res harris_at_out();
        int     w, h, y, x;
        longint sa, sb, sc, gx, gy, det, tr, t, resp;
        t_res   r;
        w = eff_width();
        h = eff_height();
        sa = 0; sb = 0; sc = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                y = out_row + dy;
                x = out_col + dx;
                if (y < 0 || x < 0 || y >= h || x >= w) continue;
                gx = ring_px(y-1, x+1, w, h) + 2*ring_px(y, x+1, w, h) + ring_px(y+1, x+1, w, h)
                   - ring_px(y-1, x-1, w, h) - 2*ring_px(y, x-1, w, h) - ring_px(y+1, x-1, w, h);
                gy = ring_px(y+1, x-1, w, h) + 2*ring_px(y+1, x, w, h) + ring_px(y+1, x+1, w, h)
                   - ring_px(y-1, x-1, w, h) - 2*ring_px(y-1, x, w, h) - ring_px(y-1, x+1, w, h);
                sa += gx*gx;
                sc += gy*gy;
                sb += gx*gy;
            end
        end
        det  = sa*sc - sb*sb;
        tr   = sa + sc;
        t    = longint'(reg_thr);
        resp = 25*det - tr*tr;
        r.row    = out_row[11:0];
        r.col    = out_col[9:0];
        r.corner = (tr > 2*t) && (t*t - t*tr + det > 0) && (resp >= 25*t);
        r.resp   = resp[51:0];
        r.last   = (out_row == h-1) && (out_col == w-1);
        if (r.last) begin
            clear_frame();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
            if (pending > 0) pending--;
        end
        return r;
    endfunction

    function automatic bit harris_step(logic mode, logic [7:0] px, output t_res r);
        int w, h;
        w = eff_width();
        h = eff_height();
        r = '0;
        if (frame_in_done) begin
            r = harris_at_out();
            return 1'b1;
        end
        if (mode) return 1'b0;
        line_ring[in_row & 7][in_col] = px;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) begin
                in_row = 0;
                frame_in_done = 1'b1;
            end
        end
        pending++;
        if (pending > 2*w + 2) begin
            r = harris_at_out();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void note_mismatch(string what, t_res e, t_res a);
        n_err++;
        if (n_err <= 10) begin
            $display("%0t %s: expected row %0d col %0d corner %0d resp %0d last %0d,",
                     $realtime, what, e.row, e.col, e.corner, e.resp, e.last);
            $display("    got row %0d col %0d corner %0d resp %0d last %0d",
                     a.row, a.col, a.corner, a.resp, a.last);
        end
    endfunction

    // output side: random stall bursts and the scoreboard
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.row, out_ch.column, out_ch.corner, out_ch.response_x25,
                        out_ch.last};
                n_beats++;
                if (got.corner) n_corners++;
                if (expected_q.size() == 0) begin
                    note_mismatch("unexpected beat", '0, got);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) note_mismatch("result mismatch", exp_r, got);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 6);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  begin reg_w = data[10:0]; clear_frame(); end
            REG_FRAME_HEIGHT: begin reg_h = data[12:0]; clear_frame(); end
            REG_THRESHOLD:    reg_thr = data;
            default:          ;
        endcase
    endtask

    task automatic send_item(logic mode, logic [7:0] px, output bit has_res, output t_res r);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= mode;
        in_ch.pixel <= px;
        do @(posedge i_clk); while (!in_ch.ready);
        has_res = harris_step(mode, px, r);
        if (has_res) expected_q.push_back(r);
    endtask

    function automatic logic [7:0] scene_px(int style, int y, int x);
        case (style)
            0: return 8'($urandom);
            1: return (((y >> 1) + (x >> 1)) & 1) ? 8'd255 : 8'd0;
            2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return 8'(y*40 + x*25 + $urandom_range(0, 15));
        endcase
    endfunction

    t_row directed [] = '{
        '{OP_CFG,   REG_FRAME_WIDTH,  24'hFFF800, 0, 0, 0},   // clamps up to 3
        '{OP_CFG,   REG_FRAME_HEIGHT, 24'h000001, 0, 0, 0},   // clamps up to 3
        '{OP_CFG,   REG_UNUSED,       24'h00ABCD, 0, 0, 0},
        '{OP_FLUSH, 0, 0, 0, 0, 0},                            // flush mid-frame: ignored
        '{OP_PIX,   0, 0, 0, 0, 0}, '{OP_PIX, 0, 0, 0, 0, 0}, '{OP_PIX, 0, 0, 0, 0, 0},
        '{OP_PIX,   0, 0, 0, 0, 0}, '{OP_PIX, 0, 0, 0, 0, 0}, '{OP_PIX, 0, 0, 0, 0, 0},
        '{OP_PIX,   0, 0, 0, 0, 0}, '{OP_PIX, 0, 0, 0, 0, 0},
        '{OP_PIX,   0, 0, 1, 0, 0},                            // flat frame: zero response
        '{OP_PIX,   0, 8'hFF, 1, 0, 0},                        // pixel while draining
        '{OP_FLUSH, 0, 0, 1, 0, 0}, '{OP_FLUSH, 0, 0, 1, 0, 0}, '{OP_FLUSH, 0, 0, 1, 0, 0},
        '{OP_FLUSH, 0, 0, 1, 0, 0}, '{OP_FLUSH, 0, 0, 1, 0, 0}, '{OP_FLUSH, 0, 0, 1, 0, 0},
        '{OP_FLUSH, 0, 0, 1, 0, 0},                            // last of the frame
        '{OP_CFG,   REG_THRESHOLD,    24'h000000, 0, 0, 0}
    };

    initial begin
        bit   has_res;
        t_res r;
        int   w, h, rand_items, style, frame_no, stop_at;
        bit   paused;
        in_ch.valid  = 1'b0;
        in_ch.mode   = 1'b0;
        in_ch.pixel  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        reg_w = RST_FRAME_WIDTH;
        reg_h = RST_FRAME_HEIGHT;
        reg_thr = RST_THRESHOLD;
        clear_frame();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].op == OP_CFG) begin
                write_reg(directed[i].idx, directed[i].data);
            end else begin
                send_item(directed[i].op == OP_FLUSH, directed[i].data[7:0], has_res, r);
                if (directed[i].chk && (!has_res || r.corner !== directed[i].exp_corner
                                        || r.resp !== directed[i].exp_resp)) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("directed row %0d: expected corner %0d resp %0d,",
                                 i, directed[i].exp_corner, directed[i].exp_resp);
                        $display("    predicted result %0d corner %0d resp %0d",
                                 has_res, r.corner, r.resp);
                    end
                end
            end
        end

        // widest and tallest geometry, only partly filled, then abandoned
        write_reg(REG_FRAME_WIDTH, {13'($urandom), 11'h7FF});
        write_reg(REG_FRAME_HEIGHT, {11'($urandom), 13'h1FFF});
        write_reg(REG_THRESHOLD, 24'hFFFFFF);
        for (int i = 0; i < WIDE_ITEMS; i++)
            send_item(1'b0, scene_px(i & 3, i / MAX_WIDTH, i % MAX_WIDTH), has_res, r);
        write_reg(REG_FRAME_WIDTH, 24'd3);
        for (int i = 0; i < 40; i++) send_item(1'b0, 8'($urandom), has_res, r);

        rand_items = 0;
        frame_no = 0;
        paused = 1'b0;
        while (rand_items < RAND_ITEMS) begin
            if (frame_no == 0 || $urandom_range(0, 2) == 0) begin
                w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
                h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
                write_reg(REG_FRAME_WIDTH, {13'($urandom), 11'(w)});
                write_reg(REG_FRAME_HEIGHT, {11'($urandom), 13'(h)});
                case ($urandom_range(0, 3))
                    0: write_reg(REG_THRESHOLD, 24'd0);
                    1: write_reg(REG_THRESHOLD, 24'hFFFFFF);
                    2: write_reg(REG_THRESHOLD, 24'($urandom_range(0, 3000)));
                    default: write_reg(REG_THRESHOLD, 24'($urandom_range(0, 2000000)));
                endcase
            end
            w = eff_width();
            h = eff_height();
            style = $urandom_range(0, 3);
            quiet = (rand_items > RAND_ITEMS - 120);
            stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w*h - 1) : w*h;
            for (int n = 0; n < stop_at; n++) begin
                if ($urandom_range(0, 15) == 0) send_item(1'b1, 8'($urandom), has_res, r);
                send_item(1'b0, scene_px(style, n / w, n % w), has_res, r);
                rand_items++;
                if (!paused && frame_no == 1 && n == stop_at / 2) begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
            if (stop_at < w*h) begin
                // abandoned frame: a geometry write restarts it
                write_reg(REG_FRAME_WIDTH, 24'(w));
            end else begin
                for (int n = 0; n < 2*w + 2; n++) begin
                    send_item($urandom_range(0, 3) != 0, 8'($urandom), has_res, r);
                    rand_items++;
                end
            end
            frame_no++;
        end

        in_ch.valid <= 1'b0;
        for (int k = 0; k < 400000 && expected_q.size() != 0; k++) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            n_err += expected_q.size();
            $display("%0d results never arrived", expected_q.size());
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d frames plus directed and edge geometries,", frame_no);
        $display("%0d result beats checked, %0d corners", n_beats, n_corners);
        if (n_err == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors", n_err);
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
